[hdl/scrambled_crc_frame_encoder_macros.svh]
// assertion macros used by the frame encoder checker
// no dependencies; included by the checker file
`ifndef SCRAMBLED_CRC_FRAME_ENCODER_MACROS_SVH
`define SCRAMBLED_CRC_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, held off during reset
`define SCFE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scfe assertion failed");

// next-cycle implication, held off during reset
`define SCFE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scfe assertion failed");

// next-cycle implication that also checks across reset
`define SCFE_ASSERT_NXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scfe assertion failed");

`endif

[hdl/scfe_pkg.sv]
// types, constants and the crc byte update for the frame encoder
// no dependencies; imported by every encoder module
package scfe_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_FIELD_W     = 16;
    localparam int TOTAL_W         = 32;
    localparam int CRC_W           = 16;
    localparam int DEF_LENGTH_BITS = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CRC_W-1:0]   CRC_POLY   = 16'h1021;
    localparam logic [TOTAL_W-1:0] LEN_OFFSET = 32'd8;

    // byte position inside the work of one item
    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_LEN0,
        ST_LEN1,
        ST_LEN2,
        ST_LEN3,
        ST_PAY,
        ST_CRC_LO,
        ST_CRC_HI
    } step_t;

    // one classified item, handed from front to back
    typedef struct packed {
        logic               start;
        logic               has_pay;
        logic               last;
        logic [BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]  sync1;
        logic [BYTE_W-1:0]  sync2;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

    // crc-16, msb first, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/scrambled_crc_frame_encoder.sv]
// top level of the scrambled crc frame encoder
// depends on scfe_pkg, scfe_front, scfe_queue and scfe_back
//
// Each input item is one payload byte. The item that opens a frame also carries
// the payload length and the two sync bytes; the block then sends both sync
// bytes, the four length bytes (payload count plus 8, little endian) and, for a
// nonzero length, the first payload byte, all but the sync bytes scrambled by
// two chained xor stages. Every later item yields its scrambled byte, and the
// last item of a frame is followed by the crc-16 (poly 0x1021, init 0) of the
// scrambled bytes, low byte first. One result byte leaves per clock from the
// back end's output register while items are queued and the sink is ready. A
// two-entry queue lets the front accept items while the back is still busy.
module scrambled_crc_frame_encoder import scfe_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_payload_byte,
    input  logic [LEN_FIELD_W-1:0] s_payload_length,
    input  logic [BYTE_W-1:0]      s_sync_first,
    input  logic [BYTE_W-1:0]      s_sync_second,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_run_end,
    output logic                   m_frame_end
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_push_cmd;
    cmd_t q_head_cmd;

    // item classification
    scfe_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_payload_length(s_payload_length),
        .s_sync_first    (s_sync_first),
        .s_sync_second   (s_sync_second),
        .q_full          (q_full),
        .push            (q_push),
        .push_cmd        (q_push_cmd)
    );

    // decoupling queue
    scfe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .head_valid(q_head_valid),
        .head_cmd  (q_head_cmd)
    );

    // byte sequencer, scrambler and crc
    scfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_end  (m_run_end),
        .m_frame_end(m_frame_end)
    );

endmodule

[hdl/scfe_queue.sv]
// short register queue of classified items between front and back
// depends on scfe_pkg for cmd_t
module scfe_queue import scfe_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/scfe_front.sv]
// front end: accepts input items, tracks frame position, classifies each item
// depends on scfe_pkg for cmd_t and the length constants
module scfe_front import scfe_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_payload_byte,
    input  logic [LEN_FIELD_W-1:0] s_payload_length,
    input  logic [BYTE_W-1:0]      s_sync_first,
    input  logic [BYTE_W-1:0]      s_sync_second,
    input  logic                   q_full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic                   in_frame_reg, in_frame_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [LENGTH_BITS-1:0] len;
    logic                   start;
    logic                   has_pay;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // classify the item and work out what is left of the frame
    always_comb begin
        len     = LENGTH_BITS'(s_payload_length);
        start   = !in_frame_reg;
        has_pay = start ? (len != '0) : 1'b1;
        if (start) begin
            bytes_left_next = has_pay ? len - LENGTH_BITS'(1) : '0;
        end else begin
            bytes_left_next = bytes_left_reg - LENGTH_BITS'(1);
        end
        in_frame_next = (bytes_left_next != '0);

        push_cmd.start   = start;
        push_cmd.has_pay = has_pay;
        push_cmd.last    = (bytes_left_next == '0);
        push_cmd.data    = s_payload_byte;
        push_cmd.sync1   = s_sync_first;
        push_cmd.sync2   = s_sync_second;
        push_cmd.total   = TOTAL_W'(len) + LEN_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
        end else if (push) begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

[hdl/scfe_back.sv]
// back end: steps through the bytes of each queued item, scrambles, runs the crc
// depends on scfe_pkg for step_t, cmd_t and crc16_byte
module scfe_back import scfe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  cmd_t              head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_run_end,
    output logic              m_frame_end
);

    step_t             step_reg;
    step_t             cur_step;
    step_t             step_next;
    logic              active_reg;
    logic              entry_done;
    logic              out_load;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              run_end_reg;
    logic              frame_end_reg, frame_end_next;
    logic [BYTE_W-1:0] fc_reg, fc_next;
    logic [BYTE_W-1:0] sc_reg, sc_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] scr_in, scr_t, scr_s;

    assign out_load = head_valid && (!m_valid_reg || m_ready);
    assign pop      = out_load && entry_done;
    assign cur_step = active_reg ? step_reg : (head_cmd.start ? ST_SYNC1 : ST_PAY);

    // next step within the item
    always_comb begin
        step_next  = cur_step;
        entry_done = 1'b0;
        unique case (cur_step)
            ST_SYNC1:  step_next = ST_SYNC2;
            ST_SYNC2:  step_next = ST_LEN0;
            ST_LEN0:   step_next = ST_LEN1;
            ST_LEN1:   step_next = ST_LEN2;
            ST_LEN2:   step_next = ST_LEN3;
            ST_LEN3:   step_next = head_cmd.has_pay ? ST_PAY : ST_CRC_LO;
            ST_PAY: begin
                step_next  = ST_CRC_LO;
                entry_done = !head_cmd.last;
            end
            ST_CRC_LO: step_next = ST_CRC_HI;
            ST_CRC_HI: entry_done = 1'b1;
            default:   entry_done = 1'b1;
        endcase
    end

    // byte selection, scrambler chains and crc
    always_comb begin
        scr_in = head_cmd.data;
        unique case (cur_step)
            ST_LEN0: scr_in = head_cmd.total[7:0];
            ST_LEN1: scr_in = head_cmd.total[15:8];
            ST_LEN2: scr_in = head_cmd.total[23:16];
            ST_LEN3: scr_in = head_cmd.total[31:24];
            default: scr_in = head_cmd.data;
        endcase
        scr_t = scr_in ^ fc_reg;
        scr_s = scr_t ^ sc_reg;

        fc_next        = fc_reg;
        sc_next        = sc_reg;
        crc_next       = crc_reg;
        frame_end_next = 1'b0;
        unique case (cur_step)
            ST_SYNC1: begin
                out_byte_next = head_cmd.sync1;
                fc_next       = head_cmd.sync1;
                sc_next       = head_cmd.sync2;
                crc_next      = '0;
            end
            ST_SYNC2:  out_byte_next = head_cmd.sync2;
            ST_LEN0, ST_LEN1, ST_LEN2, ST_LEN3, ST_PAY: begin
                out_byte_next = scr_s;
                fc_next       = scr_t;
                sc_next       = scr_s;
                crc_next      = crc16_byte(crc_reg, scr_s);
            end
            ST_CRC_LO: out_byte_next = crc_reg[7:0];
            ST_CRC_HI: begin
                out_byte_next  = crc_reg[15:8];
                frame_end_next = 1'b1;
            end
            default:   out_byte_next = crc_reg[7:0];
        endcase
    end

    // output register handshake
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
            step_reg    <= ST_SYNC1;
        end else begin
            m_valid_reg <= m_valid_next;
            if (out_load) begin
                active_reg <= !entry_done;
                step_reg   <= step_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg  <= out_byte_next;
            run_end_reg   <= entry_done;
            frame_end_reg <= frame_end_next;
            fc_reg        <= fc_next;
            sc_reg        <= sc_next;
            crc_reg       <= crc_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_end   = run_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

[hdl/scfe_checker.sv]
// port-level checks for the frame encoder, bound to the top level
// depends on scfe_pkg and scrambled_crc_frame_encoder_macros.svh
`include "scrambled_crc_frame_encoder_macros.svh"

module scfe_checker import scfe_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [BYTE_W-1:0]      s_payload_byte,
    input logic [LEN_FIELD_W-1:0] s_payload_length,
    input logic [BYTE_W-1:0]      s_sync_first,
    input logic [BYTE_W-1:0]      s_sync_second,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [BYTE_W-1:0]      m_out_byte,
    input logic                   m_run_end,
    input logic                   m_frame_end
);

    logic [BYTE_W+1:0]                   out_word;
    logic [3*BYTE_W+LEN_FIELD_W-1:0]     in_word;

    // payload of each channel gathered into one word
    assign out_word = {m_out_byte, m_run_end, m_frame_end};
    assign in_word  = {s_payload_byte, s_payload_length, s_sync_first, s_sync_second};

    // a stalled result item holds
    `SCFE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_word))

    // a stalled input item holds
    `SCFE_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(in_word))

    // the closing crc byte always ends the run of its item
    `SCFE_ASSERT_IMP(a_frame_end_run_end, aclk, aresetn, m_valid && m_frame_end, m_run_end)

    // reset empties the output register
    `SCFE_ASSERT_NXT_RST(a_reset_out_empty, aclk, !aresetn, !m_valid)

    // reset empties the queue, so input is taken right away
    `SCFE_ASSERT_NXT_RST(a_reset_in_ready, aclk, !aresetn, s_ready)

endmodule

bind scrambled_crc_frame_encoder scfe_checker u_scfe_checker (.*);

[sim/testbench.sv]
// self-checking testbench for scrambled_crc_frame_encoder
// depends on scfe_pkg and the encoder rtl; a local frame model predicts every output byte
module testbench;
    import scfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned RANDOM_ITEMS = 220;
    localparam int unsigned FRAME_CAP   = 64;
    localparam int unsigned MAX_LEN     = (1 << DEF_LENGTH_BITS) - 1;

    // one payload item as the source offers it
    typedef struct {
        logic [BYTE_W-1:0]      data;
        logic [LEN_FIELD_W-1:0] len;
        logic [BYTE_W-1:0]      sync_a;
        logic [BYTE_W-1:0]      sync_b;
        int unsigned            gap;
        bit                     drain;
        bit                     rush;
    } payload_item_t;

    // one encoded byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              frame_end;
    } frame_byte_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_payload_byte = '0;
    logic [LEN_FIELD_W-1:0] s_payload_length = '0;
    logic [BYTE_W-1:0]      s_sync_first = '0;
    logic [BYTE_W-1:0]      s_sync_second = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_out_byte;
    logic                   m_run_end;
    logic                   m_frame_end;

    payload_item_t payload_items[$];
    frame_byte_t   frame_bytes_due[$];

    // model state of the encoder
    bit                      enc_open;
    logic [LEN_FIELD_W-1:0]  enc_left;
    logic [BYTE_W-1:0]       chain_a;
    logic [BYTE_W-1:0]       chain_b;
    logic [CRC_W-1:0]        enc_crc;
    frame_byte_t             held_byte;
    bit                      held_valid;

    int unsigned items_total;
    int unsigned items_accepted;
    int unsigned bytes_checked;
    int unsigned mismatches;
    int unsigned cycle_count;

    // driver state
    payload_item_t next_item;
    payload_item_t on_offer;
    bit            have_next;
    int unsigned   idle_left;
    bit            sink_rush;

    // monitor state
    int unsigned   sink_hold;
    bit            sink_calm;

    scrambled_crc_frame_encoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload_byte   (s_payload_byte),
        .s_payload_length (s_payload_length),
        .s_sync_first     (s_sync_first),
        .s_sync_second    (s_sync_second),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_run_end        (m_run_end),
        .m_frame_end      (m_frame_end)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // both xor chains, then the crc over the scrambled byte
    function automatic logic [BYTE_W-1:0] scramble_byte(input logic [BYTE_W-1:0] x);
        logic [CRC_W-1:0] c;
        chain_a = x ^ chain_a;
        chain_b = chain_a ^ chain_b;
        c = enc_crc ^ {chain_b, 8'h00};
        repeat (8) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        enc_crc = c;
        return chain_b;
    endfunction

    // one byte is held back so the last of an item can be flagged
    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic fend);
        if (held_valid) begin
            frame_bytes_due.push_back(held_byte);
        end
        held_byte = '{out_byte: b, run_end: 1'b0, frame_end: fend};
        held_valid = 1'b1;
    endtask

    // expected output bytes of one accepted item
    task automatic encode_item(input payload_item_t it);
        logic [TOTAL_W-1:0] total;
        if (!enc_open) begin
            total = TOTAL_W'(it.len) + LEN_OFFSET;
            chain_a = it.sync_a;
            chain_b = it.sync_b;
            enc_crc = '0;
            queue_byte(it.sync_a, 1'b0);
            queue_byte(it.sync_b, 1'b0);
            for (int i = 0; i < 4; i++) begin
                queue_byte(scramble_byte(total[8*i +: 8]), 1'b0);
            end
            enc_left = it.len;
            enc_open = 1'b1;
        end
        if (enc_left != 0) begin
            queue_byte(scramble_byte(it.data), 1'b0);
            enc_left = enc_left - 1'b1;
        end
        if (enc_left == 0) begin
            queue_byte(enc_crc[7:0], 1'b0);
            queue_byte(enc_crc[15:8], 1'b1);
            enc_open = 1'b0;
        end
        held_byte.run_end = 1'b1;
        frame_bytes_due.push_back(held_byte);
        held_valid = 1'b0;
    endtask

    // queue the items of one frame; fields that only matter at the start are noise later
    // a very long frame is only opened, its first FRAME_CAP bytes are sent
    task automatic add_frame(input int unsigned len, input logic [BYTE_W-1:0] s1,
                             input logic [BYTE_W-1:0] s2, input logic [BYTE_W-1:0] first,
                             input bit drain, input bit rush);
        payload_item_t it;
        int unsigned   n;
        bit            calm;
        n = (len == 0) ? 1 : ((len > FRAME_CAP) ? FRAME_CAP : len);
        calm = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < n; k++) begin
            it.data   = (k == 0) ? first : BYTE_W'($urandom);
            it.len    = (k == 0) ? LEN_FIELD_W'(len) : LEN_FIELD_W'($urandom);
            it.sync_a = (k == 0) ? s1 : BYTE_W'($urandom);
            it.sync_b = (k == 0) ? s2 : BYTE_W'($urandom);
            it.gap    = (rush || calm) ? 0 : $urandom_range(0, 15);
            it.drain  = (k == 0) ? drain : 1'b0;
            it.rush   = rush;
            payload_items.push_back(it);
        end
        items_total += n;
    endtask

    // source side: offer queued items with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_item(on_offer);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (!have_next && payload_items.size() != 0) begin
                    next_item = payload_items.pop_front();
                    have_next = 1'b1;
                    idle_left = next_item.gap;
                end
                if (have_next && idle_left == 0 &&
                    !(next_item.drain && frame_bytes_due.size() != 0)) begin
                    on_offer = next_item;
                    have_next = 1'b0;
                    sink_rush = next_item.rush;
                    s_valid          <= 1'b1;
                    s_payload_byte   <= next_item.data;
                    s_payload_length <= next_item.len;
                    s_sync_first     <= next_item.sync_a;
                    s_sync_second    <= next_item.sync_b;
                end else begin
                    s_valid <= 1'b0;
                    if (have_next && idle_left != 0) begin
                        idle_left--;
                    end
                end
            end
        end
    end

    // sink side: check each output byte, stall at random
    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected output byte %02h", m_out_byte);
                    mismatches++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte expected %02h actual %02h", want.out_byte, m_out_byte);
                        mismatches++;
                    end
                    if (m_run_end !== want.run_end) begin
                        $error("run_end expected %0b actual %0b", want.run_end, m_run_end);
                        mismatches++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end expected %0b actual %0b", want.frame_end, m_frame_end);
                        mismatches++;
                    end
                end
                if (bytes_checked % 64 == 0) begin
                    sink_calm = ($urandom_range(0, 2) == 0);
                end
                // long hold-offs let the block fill up and push back on the source
                if (bytes_checked == 30 || bytes_checked == 500) begin
                    sink_hold = LONG_HOLD;
                end else begin
                    sink_hold = (sink_calm || sink_rush) ? 0 : $urandom_range(0, 15);
                end
            end
            if (sink_hold != 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned sel;
        int unsigned len;
        int unsigned start_count;

        // directed frames: empty frames, single-byte and short frames, odd sync values
        add_frame(0, 8'h01, 8'h00, 8'hff, 1'b1, 1'b0);
        add_frame(0, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
        add_frame(1, 8'hff, 8'hfe, 8'h00, 1'b0, 1'b0);
        add_frame(1, 8'h80, 8'h7f, 8'hff, 1'b0, 1'b0);
        add_frame(3, 8'h5a, 8'ha5, 8'h00, 1'b1, 1'b0);
        add_frame(2, 8'h00, 8'hff, 8'hff, 1'b0, 1'b0);
        add_frame(4, 8'h01, 8'h00, 8'h55, 1'b0, 1'b0);
        add_frame(0, 8'hff, 8'h00, 8'haa, 1'b0, 1'b0);

        // random frames, mostly short
        start_count = items_total;
        while (items_total - start_count < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                len = $urandom_range(0, 4);
            end else if (sel < 9) begin
                len = $urandom_range(5, 16);
            end else begin
                len = $urandom_range(17, 60);
            end
            add_frame(len, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      ($urandom_range(0, 15) == 0), 1'b0);
        end

        // longest frame opened last, sent back to back
        add_frame(MAX_LEN, 8'hc3, 8'h3c, 8'h00, 1'b1, 1'b1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != items_total) @(posedge aclk);
        while (frame_bytes_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/scfe_pkg.sv
hdl/scfe_queue.sv
hdl/scfe_front.sv
hdl/scfe_back.sv
hdl/scrambled_crc_frame_encoder.sv
hdl/scfe_checker.sv
sim/testbench.sv
